[hdl/lse_pkg.sv]
package lse_pkg;

    // Field widths of the stream payload.
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    // Command codes carried on the slave tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH      = 3'd0,
        CMD_POP       = 3'd1,
        CMD_PEEK      = 3'd2,
        CMD_CLEAR     = 3'd3,
        CMD_WALK_DOWN = 3'd4,
        CMD_WALK_UP   = 3'd5
    } t_cmd;

    // Status codes carried on the master tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

endpackage

[hdl/lifo_stack_engine.sv]
// LIFO stack engine: a last-in-first-out store of words kept in one
// synchronous memory of DEPTH entries.
// Slave channel: i_s_tuser carries the command (push, pop, peek, clear,
// walk top-down, walk bottom-up), i_s_tdata the word for a push.
// Master channel: one item per command, or one per stored entry for a
// walk; o_m_tlast marks the final item of a command, o_m_tuser the status.
// Every item also carries the depth, empty and full flags and space left.
// The capacity register (1..DEPTH, reset DEPTH) is written through
// i_cfg_we / i_cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce. A capacity below the
// current depth trims the depth and keeps the bottom entries.
// Timing: the accept cycle of a command issues the memory read of the top
// entry (bottom for an upward walk); the result is registered in the work
// state once the output register is free. A walk gives one item per cycle
// from the read port while the receiver does not stall.
// One command is in work at a time; a new command is taken as soon as the
// previous one has placed its last item in the output register, even if
// that item is still waiting. A stalled receiver holds the output register
// and the block waits. Reset empties the stack and sets capacity to DEPTH;
// memory contents are not cleared.
module lifo_stack_engine #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: capacity register.
    input  logic                          i_cfg_we,
    input  logic [lse_pkg::COUNT_W-1:0]   i_cfg_wdata,
    // Slave channel.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [lse_pkg::S_DATA_W-1:0]  i_s_tdata,  // [31:0] push_word
    input  logic [lse_pkg::CMD_W-1:0]     i_s_tuser,  // [2:0] command
    // Master channel.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [31:0] word_out, [38:32] depth, [39] is_empty, [40] is_full,
    // [47:41] space_left
    output logic [lse_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic [lse_pkg::STATUS_W-1:0]  o_m_tuser,  // [1:0] status
    output logic                          o_m_tlast
);
    import lse_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int EXT_W  = (WORD_BITS > WORD_W) ? WORD_BITS : WORD_W;

    typedef enum logic {
        S_IDLE,
        S_WORK
    } t_state;

    // Control and data registers.
    t_state                 r_state;
    t_cmd                   r_cmd;
    logic [WORD_BITS-1:0]   r_word;
    logic [CNT_W-1:0]       r_top;
    logic [CNT_W-1:0]       r_cap;
    logic [CNT_W-1:0]       r_walk_cnt;
    logic [ADDR_W-1:0]      r_rd_addr;
    logic                   r_m_valid;
    logic [WORD_W-1:0]      r_m_word;
    t_status                r_m_status;
    logic [COUNT_W-1:0]     r_m_depth;
    logic                   r_m_empty;
    logic                   r_m_full;
    logic [COUNT_W-1:0]     r_m_space;
    logic                   r_m_last;

    // Memory and its registered read data.
    logic [WORD_BITS-1:0]   mem [DEPTH];
    logic [WORD_BITS-1:0]   r_rd_data;

    logic                   s_accept;
    logic                   out_free;
    logic [CNT_W-1:0]       top_m1;
    logic [EXT_W-1:0]       push_ext;
    logic [EXT_W-1:0]       rd_ext;
    logic                   emit;
    logic [WORD_W-1:0]      e_word;
    t_status                e_status;
    logic                   e_last;
    logic [CNT_W-1:0]       n_top;
    logic                   walk_more;
    logic                   mem_we;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [COUNT_W-1:0]     cfg_val;
    logic [CNT_W-1:0]       cfg_cap;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;
    assign top_m1     = r_top - CNT_W'(1);
    assign push_ext   = EXT_W'(i_s_tdata);
    assign rd_ext     = EXT_W'(r_rd_data);

    // Command execution: decide the result and the new depth.
    always_comb begin
        emit      = 1'b0;
        e_word    = '0;
        e_status  = ST_OK;
        e_last    = 1'b1;
        n_top     = r_top;
        walk_more = 1'b0;
        mem_we    = 1'b0;
        if (r_state == S_WORK && out_free) begin
            emit = 1'b1;
            unique case (r_cmd)
                CMD_PUSH: begin
                    if (r_top >= r_cap) begin
                        e_status = ST_OVERFLOW;
                    end else begin
                        mem_we = 1'b1;
                        n_top  = r_top + CNT_W'(1);
                    end
                end
                CMD_POP, CMD_PEEK: begin
                    if (r_top == '0) begin
                        e_status = ST_EMPTY;
                    end else begin
                        e_word = rd_ext[WORD_W-1:0];
                        if (r_cmd == CMD_POP) begin
                            n_top = top_m1;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_top = '0;
                end
                CMD_WALK_DOWN, CMD_WALK_UP: begin
                    if (r_top == '0) begin
                        e_status = ST_EMPTY;
                    end else begin
                        e_word    = rd_ext[WORD_W-1:0];
                        e_last    = (r_walk_cnt == top_m1);
                        walk_more = !e_last;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Read port: top entry (or bottom for an upward walk) at accept, then
    // the next entry for each walk step.
    always_comb begin
        rd_en   = s_accept || walk_more;
        rd_addr = '0;
        if (s_accept) begin
            if (t_cmd'(i_s_tuser) != CMD_WALK_UP) begin
                rd_addr = top_m1[ADDR_W-1:0];
            end
        end else if (r_cmd == CMD_WALK_DOWN) begin
            rd_addr = r_rd_addr - ADDR_W'(1);
        end else begin
            rd_addr = r_rd_addr + ADDR_W'(1);
        end
    end

    // Capacity write, clamped to the range 1..DEPTH.
    always_comb begin
        cfg_val = i_cfg_wdata;
        if (cfg_val == '0) begin
            cfg_val = COUNT_W'(1);
        end else if (cfg_val > COUNT_W'(DEPTH)) begin
            cfg_val = COUNT_W'(DEPTH);
        end
        cfg_cap = CNT_W'(cfg_val);
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_top[ADDR_W-1:0]] <= r_word;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Sequencer, stack pointer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_top      <= '0;
            r_cap      <= CNT_W'(DEPTH);
            r_walk_cnt <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_state    <= S_WORK;
                        r_walk_cnt <= '0;
                    end
                end
                S_WORK: begin
                    if (emit && !walk_more) begin
                        r_state <= S_IDLE;
                    end
                    if (walk_more) begin
                        r_walk_cnt <= r_walk_cnt + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_cap <= cfg_cap;
                r_top <= (r_top > cfg_cap) ? cfg_cap : r_top;
            end else begin
                r_top <= n_top;
            end
        end

        // Payload registers.
        if (s_accept) begin
            r_cmd  <= t_cmd'(i_s_tuser);
            r_word <= push_ext[WORD_BITS-1:0];
        end
        if (rd_en) begin
            r_rd_addr <= rd_addr;
        end
        if (emit) begin
            r_m_word   <= e_word;
            r_m_status <= e_status;
            r_m_last   <= e_last;
            r_m_depth  <= COUNT_W'(n_top);
            r_m_empty  <= (n_top == '0);
            r_m_full   <= (n_top == r_cap);
            r_m_space  <= COUNT_W'(r_cap - n_top);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_space, r_m_full, r_m_empty, r_m_depth, r_m_word};
    assign o_m_tuser  = r_m_status;
    assign o_m_tlast  = r_m_last;

    // The depth never exceeds the capacity.
    a_top_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= r_cap)
        else $error("stack depth above capacity");

    // Only one command is in work: an accepted item closes the slave side.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("second item accepted while a command is in work");

    // A walk step never runs past the stored entries.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WORK && (r_cmd == CMD_WALK_DOWN || r_cmd == CMD_WALK_UP)
            && r_top != '0) |-> r_walk_cnt < r_top)
        else $error("walk index beyond depth");

    // A refused push is only reported on a full stack.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status == ST_OVERFLOW) |-> r_m_full)
        else $error("overflow reported on a stack that is not full");

endmodule

[tb/stack_result_checker.sv]
module stack_result_checker
    import lse_pkg::*;
#(
    parameter int STACK_ENTRIES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [COUNT_W-1:0]   i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_DATA_W-1:0]  i_s_tdata,
    input  logic [CMD_W-1:0]     i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_DATA_W-1:0]  i_m_tdata,
    input  logic [STATUS_W-1:0]  i_m_tuser,
    input  logic                 i_m_tlast,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [WORD_W-1:0]  word_out;
        t_status            status;
        logic [COUNT_W-1:0] depth;
        logic               is_empty;
        logic               is_full;
        logic [COUNT_W-1:0] space_left;
        logic               last;
    } t_stack_result;

    // Shadow copy of the stack and its capacity register.
    logic [WORD_W-1:0]  stored_words [STACK_ENTRIES];
    logic [COUNT_W-1:0] stack_depth;
    logic [COUNT_W-1:0] capacity_limit;

    t_stack_result expected_results [$];
    t_stack_result seen_result;
    t_stack_result due_result;

    // Queue one result, with the flags taken from the current depth.
    task automatic queue_result(input logic [WORD_W-1:0] word, input t_status status,
                                input logic last);
        t_stack_result r;
        r.word_out   = word;
        r.status     = status;
        r.depth      = stack_depth;
        r.is_empty   = (stack_depth == '0);
        r.is_full    = (stack_depth == capacity_limit);
        r.space_left = capacity_limit - stack_depth;
        r.last       = last;
        expected_results.push_back(r);
    endtask

    // Capacity writes are clamped to 1..STACK_ENTRIES and trim the depth.
    task automatic apply_capacity(input logic [COUNT_W-1:0] value);
        logic [COUNT_W-1:0] v;
        v = value;
        if (v == '0) begin
            v = COUNT_W'(1);
        end
        if (v > COUNT_W'(STACK_ENTRIES)) begin
            v = COUNT_W'(STACK_ENTRIES);
        end
        capacity_limit = v;
        if (stack_depth > capacity_limit) begin
            stack_depth = capacity_limit;
        end
    endtask

    // Work out every result caused by one accepted command.
    task automatic predict_stack_command(input logic [CMD_W-1:0] cmd,
                                         input logic [WORD_W-1:0] word);
        int n;
        int idx;
        case (cmd)
            CMD_PUSH: begin
                if (stack_depth >= capacity_limit) begin
                    queue_result('0, ST_OVERFLOW, 1'b1);
                end else begin
                    stored_words[stack_depth] = word;
                    stack_depth = stack_depth + 1'b1;
                    queue_result('0, ST_OK, 1'b1);
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (stack_depth == '0) begin
                    queue_result('0, ST_EMPTY, 1'b1);
                end else begin
                    word = stored_words[stack_depth - 1'b1];
                    if (cmd == CMD_POP) begin
                        stack_depth = stack_depth - 1'b1;
                    end
                    queue_result(word, ST_OK, 1'b1);
                end
            end
            CMD_CLEAR: begin
                stack_depth = '0;
                queue_result('0, ST_OK, 1'b1);
            end
            CMD_WALK_DOWN, CMD_WALK_UP: begin
                n = int'(stack_depth);
                if (n == 0) begin
                    queue_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        idx = (cmd == CMD_WALK_DOWN) ? (n - 1 - i) : i;
                        queue_result(stored_words[idx], ST_OK, i == n - 1);
                    end
                end
            end
            default: begin
                // Unused command codes do nothing but still answer.
                queue_result('0, ST_OK, 1'b1);
            end
        endcase
    endtask

    task automatic compare_field(input string field, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            o_fail_count++;
        end
    endtask

    // Results are compared before the command of the same edge is predicted;
    // a command never produces its result at the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stack_depth    = '0;
            capacity_limit = COUNT_W'(STACK_ENTRIES);
            o_fail_count   = 0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen_result.word_out   = i_m_tdata[31:0];
                seen_result.depth      = i_m_tdata[38:32];
                seen_result.is_empty   = i_m_tdata[39];
                seen_result.is_full    = i_m_tdata[40];
                seen_result.space_left = i_m_tdata[47:41];
                seen_result.status     = t_status'(i_m_tuser);
                seen_result.last       = i_m_tlast;
                if (expected_results.size() == 0) begin
                    $error("Unexpected result item: tdata 0x%0h, tuser %0d, tlast %0b",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                    o_fail_count++;
                end else begin
                    due_result = expected_results.pop_front();
                    compare_field("word_out", due_result.word_out, seen_result.word_out);
                    compare_field("status", due_result.status, seen_result.status);
                    compare_field("depth", due_result.depth, seen_result.depth);
                    compare_field("is_empty", due_result.is_empty, seen_result.is_empty);
                    compare_field("is_full", due_result.is_full, seen_result.is_full);
                    compare_field("space_left", due_result.space_left,
                                  seen_result.space_left);
                    compare_field("last", due_result.last, seen_result.last);
                end
            end
            if (i_cfg_we) begin
                apply_capacity(i_cfg_wdata);
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_stack_command(i_s_tuser, i_s_tdata);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

[tb/testbench.sv]
module testbench;
    import lse_pkg::*;

    // Command codes the block treats as no operation.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [COUNT_W-1:0]   i_cfg_wdata;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata;   // [31:0] push_word
    logic [CMD_W-1:0]     i_s_tuser;   // [2:0] command
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    // [31:0] word_out, [38:32] depth, [39] is_empty, [40] is_full, [47:41] space_left
    logic [M_DATA_W-1:0]  o_m_tdata;
    logic [STATUS_W-1:0]  o_m_tuser;   // [1:0] status
    logic                 o_m_tlast;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;

    lifo_stack_engine #(
        .DEPTH     (64),
        .WORD_BITS (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    stack_result_checker #(
        .STACK_ENTRIES (64)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stalls at random with the current idle rate.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one item after an optional random gap and hold it until accepted.
    // Valid is only lowered during a gap, so it never toggles within one step.
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic [S_DATA_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic wait_until_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Fill bursts favor pushes so the stack gets deep; other bursts drain it.
    function automatic logic [CMD_W-1:0] pick_command(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r < (filling ? 70 : 30)) begin
            return CMD_PUSH;
        end
        case (r % 10)
            0, 1, 2, 3: return CMD_POP;
            4, 5:       return CMD_PEEK;
            6:          return CMD_WALK_DOWN;
            7:          return CMD_WALK_UP;
            8:          return (r < 50) ? CMD_CLEAR : CMD_POP;
            default:    return r[0] ? CMD_SPARE_7 : CMD_SPARE_6;
        endcase
    endfunction

    // Random items with a capacity change half way through.
    task automatic run_random_phase(input int count);
        bit filling;
        filling = 1'b1;
        for (int k = 0; k < count; k++) begin
            if (k % 16 == 0) begin
                filling = 1'($urandom_range(1));
            end
            if (k == count / 2) begin
                wait_until_drained();
                write_capacity(COUNT_W'($urandom_range(0, 127)));
            end
            issue_command(pick_command(filling), $urandom);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = CMD_PUSH;
        send_idle_pct = 6;
        recv_idle_pct = 61;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty stack, extreme words, every command but clear at reset capacity.
        issue_command(CMD_POP, $urandom);
        issue_command(CMD_PEEK, $urandom);
        issue_command(CMD_WALK_DOWN, $urandom);
        issue_command(CMD_WALK_UP, $urandom);
        issue_command(CMD_PUSH, 32'h0000_0000);
        issue_command(CMD_PUSH, 32'hFFFF_FFFF);
        issue_command(CMD_PUSH, 32'hAAAA_AAAA);
        issue_command(CMD_PUSH, 32'h5555_5555);
        issue_command(CMD_PEEK, $urandom);
        issue_command(CMD_WALK_DOWN, $urandom);
        issue_command(CMD_WALK_UP, $urandom);
        issue_command(CMD_POP, $urandom);
        issue_command(CMD_SPARE_6, $urandom);
        issue_command(CMD_SPARE_7, $urandom);

        // A zero capacity reads as one and trims the depth to the bottom entry.
        wait_until_drained();
        write_capacity(7'd0);
        issue_command(CMD_PUSH, $urandom);
        issue_command(CMD_PEEK, $urandom);
        issue_command(CMD_WALK_DOWN, $urandom);

        // A capacity above the memory size reads as the full size.
        wait_until_drained();
        write_capacity(7'd127);
        issue_command(CMD_CLEAR, $urandom);
        issue_command(CMD_PUSH, $urandom);
        issue_command(CMD_POP, $urandom);

        // Small capacities, with the receiver stalling often.
        wait_until_drained();
        write_capacity(COUNT_W'($urandom_range(2, 8)));
        run_random_phase(32);

        // Middle capacities, with the sender idling often.
        send_idle_pct = 61;
        recv_idle_pct = 6;
        wait_until_drained();
        write_capacity(COUNT_W'($urandom_range(9, 63)));
        run_random_phase(32);

        // Full size without idling: fill past capacity, walk it, then random.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_until_drained();
        write_capacity(7'd64);
        for (int k = 0; k < 65; k++) begin
            issue_command(CMD_PUSH, $urandom);
        end
        issue_command(CMD_WALK_DOWN, $urandom);
        issue_command(CMD_WALK_UP, $urandom);
        run_random_phase(32);

        wait_until_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
hdl/lse_pkg.sv
hdl/lifo_stack_engine.sv
tb/stack_result_checker.sv
tb/testbench.sv
